[rtl/core/latency_window_statistics_defines.svh]
// Assertion macros used by the latency window statistics RTL.
`ifndef LATENCY_WINDOW_STATISTICS_DEFINES_SVH
`define LATENCY_WINDOW_STATISTICS_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define LWS_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define LWS_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/lws_pkg.sv]
// Shared constants for the latency window statistics block.
package lws_pkg;
    localparam int STORE_DEPTH_DEFAULT = 1024;
    localparam int TIME_W = 52;
    localparam int GAP_W = 31;
    localparam int CNT_W = 32;
    localparam int IVL_W = 12;
    localparam int IVL_US_W = 32;
    localparam logic [19:0] US_PER_SEC = 20'd1000000;
    localparam logic [GAP_W-1:0] MIN_INIT = 31'd5000000;
    localparam logic [GAP_W-1:0] MAX_INIT = 31'd1;
    localparam logic [GAP_W-1:0] GAP_MAX = 31'h7FFFFFFF;
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [IVL_W-1:0] IVL_RESET = 12'd2;
    localparam logic CFG_INTERVAL = 1'b0;
    localparam logic CFG_AVERAGE = 1'b1;
    localparam logic CMD_START = 1'b0;
endpackage

[rtl/core/lws_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module lws_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end
endmodule

[rtl/core/latency_window_statistics.sv]
// Top level of the windowed latency statistics block.
// Each request is accepted in the idle state and then handled in the update
// state, so the block cannot take a new sample or start request before it is
// through with the last one. A sample that closes a measured window also walks
// the gap store: 31 selection passes over the single RAM read port find the
// median (the first pass also sums the gaps), then a one-bit-per-cycle divider
// forms the mean. The input is not ready while a request is in work. A sample
// that closes a window with a result waits in its update state while an
// earlier result is still held on the output, so a waiting result alone does
// not block the next request. The store has no reset and is only read where
// written since the last window was cleared.
module latency_window_statistics #(
    parameter int STORE_DEPTH = lws_pkg::STORE_DEPTH_DEFAULT
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [55:0]              s_tdata,   // timestamp_us[51:0], zero pad
    input  logic                     s_tuser,   // command
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // window_secs, max_latency, min_latency, mean_latency, median_latency,
    // sample_count, wrap_count, zero pad
    output logic [223:0]             m_tdata,
    output logic                     m_tuser,   // has_stats
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic                     cfg_index,
    input  logic [lws_pkg::IVL_W-1:0] cfg_data
);
    import lws_pkg::*;

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int CW = $clog2(STORE_DEPTH + 1);
    localparam int SW = GAP_W + CW;
    localparam int DW = $clog2(SW + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(STORE_DEPTH);
    localparam logic [CNT_W:0] DEPTH_W = (CNT_W + 1)'(STORE_DEPTH);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_UPD  = 3'd1;
    localparam logic [2:0] ST_SCAN = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;

    logic [2:0]          state_reg;
    logic [IVL_W-1:0]    interval_reg;
    logic [IVL_US_W-1:0] interval_us_reg;
    logic                average_reg;
    logic                cmd_reg;
    logic [TIME_W-1:0]   time_reg;
    logic [TIME_W-1:0]   prev_reg;
    logic [TIME_W-1:0]   deadline_reg;
    logic [CNT_W-1:0]    offset_reg;
    logic [GAP_W-1:0]    max_reg;
    logic [GAP_W-1:0]    min_reg;
    logic [CNT_W-1:0]    samples_reg;
    logic [CNT_W-1:0]    wraps_reg;
    logic [CW-1:0]       windex_reg;
    logic [CW-1:0]       bsize_reg;
    logic                calib_reg;

    logic [CW-1:0]       cnt_reg;
    logic [CW-1:0]       issue_reg;
    logic                rd_vld_reg;
    logic [CW-1:0]       match_reg;
    logic [CW-1:0]       rank_reg;
    logic [GAP_W-1:0]    med_reg;
    logic [GAP_W-1:0]    bit_reg;
    logic [GAP_W-1:0]    mask_reg;
    logic [SW-1:0]       quo_reg;
    logic [CW:0]         rem_reg;
    logic [DW-1:0]       div_cnt_reg;

    logic                m_valid_reg;
    logic [CNT_W-1:0]    o_secs_reg;
    logic [GAP_W-1:0]    o_max_reg;
    logic [GAP_W-1:0]    o_min_reg;
    logic [CNT_W-1:0]    o_mean_reg;
    logic [GAP_W-1:0]    o_med_reg;
    logic [CNT_W-1:0]    o_samples_reg;
    logic [CNT_W-1:0]    o_wraps_reg;
    logic                o_stats_reg;

    logic [TIME_W-1:0]   diff;
    logic [GAP_W-1:0]    gap;
    logic [TIME_W:0]     dl_sum;
    logic [TIME_W-1:0]   dl_next;
    logic [CNT_W-1:0]    samples_inc;
    logic [CNT_W-1:0]    wraps_inc;
    logic [CW-1:0]       windex_inc;
    logic                wrap_hit;
    logic [CNT_W-1:0]    samples_after;
    logic                report;
    logic                out_busy;
    logic [CNT_W:0]      bsize_raw;
    logic [CW-1:0]       bsize_new;
    logic [CW-1:0]       cnt_new;
    logic                ram_we;
    logic [GAP_W-1:0]    rd_data;
    logic                is_match;
    logic [CW:0]         trial;
    logic                trial_ge;
    logic [GAP_W-1:0]    max_base;
    logic [GAP_W-1:0]    min_base;

    assign s_tready = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid = m_valid_reg;
    assign m_tuser = o_stats_reg;
    assign m_tdata = {3'b000, o_wraps_reg, o_samples_reg, o_med_reg, o_mean_reg,
                      o_min_reg, o_max_reg, o_secs_reg};

    always_comb begin
        diff = time_reg - prev_reg;
        if (time_reg <= prev_reg) begin
            gap = '0;
        end else if (diff > TIME_W'(GAP_MAX)) begin
            gap = GAP_MAX;
        end else begin
            gap = diff[GAP_W-1:0];
        end
        dl_sum = {1'b0, time_reg} + (TIME_W + 1)'(interval_us_reg);
        dl_next = dl_sum[TIME_W] ? TIME_MAX : dl_sum[TIME_W-1:0];
        samples_inc = (samples_reg == CNT_MAX) ? samples_reg : samples_reg + 1'b1;
        wraps_inc = (wraps_reg == CNT_MAX) ? wraps_reg : wraps_reg + 1'b1;
        windex_inc = windex_reg + 1'b1;
        wrap_hit = !calib_reg && (windex_inc >= bsize_reg);
        samples_after = wrap_hit ? '0 : samples_inc;
        report = time_reg >= deadline_reg;
        out_busy = (cmd_reg != CMD_START) && report && (!calib_reg || !average_reg)
                   && m_valid_reg && !m_tready;
        bsize_raw = {1'b0, samples_inc} + {2'b00, samples_inc[CNT_W-1:1]};
        if (bsize_raw > DEPTH_W) begin
            bsize_new = DEPTH_C;
        end else if (bsize_raw == '0) begin
            bsize_new = CW'(1);
        end else begin
            bsize_new = bsize_raw[CW-1:0];
        end
        cnt_new = ({1'b0, samples_after} > DEPTH_W) ? DEPTH_C : samples_after[CW-1:0];
        ram_we = (state_reg == ST_UPD) && (cmd_reg != CMD_START) && !calib_reg
                 && !out_busy;
        is_match = (((rd_data ^ med_reg) & mask_reg) == '0) && ((rd_data & bit_reg) == '0);
        trial = {rem_reg[CW-1:0], quo_reg[SW-1]};
        trial_ge = trial >= {1'b0, cnt_reg};
        max_base = (report && (!calib_reg || !average_reg)) ? MAX_INIT : max_reg;
        min_base = (report && (!calib_reg || !average_reg)) ? MIN_INIT : min_reg;
    end

    lws_ram #(
        .WIDTH(GAP_W),
        .DEPTH(STORE_DEPTH)
    ) u_store (
        .aclk   (aclk),
        .wr_en  (ram_we),
        .wr_addr(windex_reg[AW-1:0]),
        .wr_data(gap),
        .rd_addr(issue_reg[AW-1:0]),
        .rd_data(rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            interval_reg <= IVL_RESET;
            interval_us_reg <= IVL_US_W'(IVL_RESET) * IVL_US_W'(US_PER_SEC);
            average_reg <= 1'b0;
            prev_reg <= '0;
            deadline_reg <= '0;
            offset_reg <= '0;
            max_reg <= MAX_INIT;
            min_reg <= MIN_INIT;
            samples_reg <= '0;
            wraps_reg <= '0;
            windex_reg <= '0;
            bsize_reg <= '0;
            calib_reg <= 1'b1;
            rd_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_INTERVAL: begin
                        interval_reg <= cfg_data;
                        interval_us_reg <= IVL_US_W'(cfg_data) * IVL_US_W'(US_PER_SEC);
                    end
                    CFG_AVERAGE: average_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            rd_vld_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid && s_tready) begin
                        cmd_reg <= s_tuser;
                        time_reg <= s_tdata[TIME_W-1:0];
                        state_reg <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    if (out_busy) begin
                        state_reg <= ST_UPD;
                    end else if (cmd_reg == CMD_START) begin
                        state_reg <= ST_IDLE;
                        prev_reg <= time_reg;
                        deadline_reg <= dl_next;
                        offset_reg <= '0;
                        max_reg <= MAX_INIT;
                        min_reg <= MIN_INIT;
                        samples_reg <= '0;
                        wraps_reg <= '0;
                        windex_reg <= '0;
                        bsize_reg <= '0;
                        calib_reg <= 1'b1;
                    end else begin
                        state_reg <= ST_IDLE;
                        prev_reg <= time_reg;
                        max_reg <= (gap > max_base) ? gap : max_base;
                        min_reg <= (gap < min_base) ? gap : min_base;
                        samples_reg <= samples_after;
                        if (!calib_reg) begin
                            windex_reg <= wrap_hit ? '0 : windex_inc;
                            if (wrap_hit) begin
                                wraps_reg <= wraps_inc;
                            end
                        end
                        if (report) begin
                            offset_reg <= offset_reg + CNT_W'(interval_reg);
                            deadline_reg <= dl_next;
                            o_secs_reg <= offset_reg;
                            o_max_reg <= max_reg;
                            o_min_reg <= min_reg;
                            o_samples_reg <= samples_after;
                            if (!calib_reg) begin
                                o_wraps_reg <= wrap_hit ? wraps_inc : wraps_reg;
                                o_stats_reg <= 1'b1;
                                samples_reg <= '0;
                                wraps_reg <= '0;
                                windex_reg <= '0;
                                cnt_reg <= cnt_new;
                                rank_reg <= cnt_new >> 1;
                                issue_reg <= '0;
                                match_reg <= '0;
                                med_reg <= '0;
                                bit_reg <= {1'b1, {(GAP_W - 1){1'b0}}};
                                mask_reg <= '0;
                                quo_reg <= '0;
                                rem_reg <= '0;
                                div_cnt_reg <= '0;
                                if (cnt_new == '0) begin
                                    o_mean_reg <= '0;
                                    o_med_reg <= '0;
                                    m_valid_reg <= 1'b1;
                                end else begin
                                    state_reg <= ST_SCAN;
                                end
                            end else if (!average_reg) begin
                                o_wraps_reg <= '0;
                                o_stats_reg <= 1'b0;
                                o_mean_reg <= '0;
                                o_med_reg <= '0;
                                samples_reg <= '0;
                                wraps_reg <= '0;
                                windex_reg <= '0;
                                m_valid_reg <= 1'b1;
                            end else begin
                                bsize_reg <= bsize_new;
                                calib_reg <= 1'b0;
                                samples_reg <= '0;
                                windex_reg <= '0;
                            end
                        end
                    end
                end
                ST_SCAN: begin
                    if (issue_reg != cnt_reg) begin
                        issue_reg <= issue_reg + 1'b1;
                        rd_vld_reg <= 1'b1;
                    end
                    if (rd_vld_reg) begin
                        if (is_match) begin
                            match_reg <= match_reg + 1'b1;
                        end
                        if (bit_reg[GAP_W-1]) begin
                            quo_reg <= quo_reg + SW'(rd_data);
                        end
                    end
                    if ((issue_reg == cnt_reg) && !rd_vld_reg) begin
                        if (rank_reg >= match_reg) begin
                            med_reg <= med_reg | bit_reg;
                            rank_reg <= rank_reg - match_reg;
                        end
                        bit_reg <= bit_reg >> 1;
                        mask_reg <= mask_reg | bit_reg;
                        match_reg <= '0;
                        issue_reg <= '0;
                        if (bit_reg[0]) begin
                            state_reg <= ST_DIV;
                        end
                    end
                end
                ST_DIV: begin
                    rem_reg <= trial_ge ? trial - {1'b0, cnt_reg} : trial;
                    quo_reg <= {quo_reg[SW-2:0], trial_ge};
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                    if (div_cnt_reg == DW'(SW - 1)) begin
                        o_mean_reg <= {quo_reg[CNT_W-2:0], trial_ge};
                        o_med_reg <= med_reg;
                        m_valid_reg <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

`include "latency_window_statistics_defines.svh"

    `LWS_ASSERT_NOW(a_no_accept_while_busy, s_tready, state_reg == ST_IDLE, "input ready while busy")
    `LWS_ASSERT_NEXT(a_accept_to_update, s_tvalid && s_tready, state_reg == ST_UPD, "accepted request skipped update")
    `LWS_ASSERT_NOW(a_index_in_buffer, !calib_reg, windex_reg < bsize_reg, "write index beyond buffer size")
    `LWS_ASSERT_NOW(a_max_nonzero, 1'b1, max_reg != '0, "max gap fell to zero")
endmodule

[verif/tb_latency_window_statistics.sv]
// Self-checking testbench for the windowed latency statistics block.
module tb_latency_window_statistics;
    import lws_pkg::*;

    localparam int  DEPTH       = STORE_DEPTH_DEFAULT;
    localparam int  CYCLE_LIMIT = 1500000;
    localparam int  HOLD_CYCLES = 4000;
    localparam int  DRAIN_WAIT  = 100;

    typedef struct packed {
        logic [CNT_W-1:0] wrap_count;
        logic [CNT_W-1:0] sample_count;
        logic [GAP_W-1:0] median_latency;
        logic [31:0]      mean_latency;
        logic [GAP_W-1:0] min_latency;
        logic [GAP_W-1:0] max_latency;
        logic [31:0]      window_secs;
    } report_t;

    typedef struct {
        report_t  rpt;
        logic     has_stats;
    } window_report_t;

    class window_scoreboard;
        logic [IVL_W-1:0]  interval_secs;
        logic              average_on;
        logic [TIME_W-1:0] last_time;
        logic [TIME_W-1:0] deadline;
        logic [31:0]       offset_secs;
        logic [GAP_W-1:0]  max_gap;
        logic [GAP_W-1:0]  min_gap;
        logic [CNT_W-1:0]  samples;
        logic [CNT_W-1:0]  wraps;
        int                wr_index;
        int                store_size;
        bit                calibrating;
        logic [GAP_W-1:0]  gap_mem [DEPTH];
        window_report_t    pending_reports[$];
        int                errors;

        function new();
            interval_secs = IVL_RESET;
            average_on = 1'b0;
            last_time = '0;
            deadline = '0;
            offset_secs = '0;
            store_size = 0;
            calibrating = 1'b1;
            errors = 0;
            clear_window();
        endfunction

        function void clear_window();
            max_gap = MAX_INIT;
            min_gap = MIN_INIT;
            samples = '0;
            wraps = '0;
            wr_index = 0;
        endfunction

        function logic [TIME_W-1:0] deadline_after(logic [TIME_W-1:0] t);
            logic [63:0] d;
            d = 64'(t) + 64'(interval_secs) * 64'd1000000;
            return (d > 64'(TIME_MAX)) ? TIME_MAX : d[TIME_W-1:0];
        endfunction

        function void write_reg(logic idx, logic [IVL_W-1:0] val);
            if (idx == CFG_INTERVAL) begin
                interval_secs = val;
            end else begin
                average_on = val[0];
            end
        endfunction

        function void note_request(logic cmd, logic [TIME_W-1:0] t);
            logic [GAP_W-1:0] gap;
            logic [TIME_W-1:0] diff;
            window_report_t r;
            logic [63:0] sum;
            int cnt;
            logic [GAP_W-1:0] sorted[$];
            if (cmd == CMD_START) begin
                last_time = t;
                deadline = deadline_after(t);
                offset_secs = '0;
                clear_window();
                store_size = 0;
                calibrating = 1'b1;
                return;
            end
            diff = t - last_time;
            if (t <= last_time) begin
                gap = '0;
            end else if (diff > TIME_W'(GAP_MAX)) begin
                gap = GAP_MAX;
            end else begin
                gap = diff[GAP_W-1:0];
            end
            if (samples != CNT_MAX) samples++;
            if (!calibrating) begin
                if (wr_index < DEPTH) gap_mem[wr_index] = gap;
                wr_index++;
                if (wr_index >= store_size) begin
                    wr_index = 0;
                    if (wraps != CNT_MAX) wraps++;
                    samples = '0;
                end
            end
            if (t >= deadline) begin
                if (!calibrating || !average_on) begin
                    r.rpt.window_secs = offset_secs;
                    r.rpt.max_latency = max_gap;
                    r.rpt.min_latency = min_gap;
                    r.rpt.sample_count = samples;
                    r.rpt.mean_latency = '0;
                    r.rpt.median_latency = '0;
                    r.rpt.wrap_count = '0;
                    r.has_stats = 1'b0;
                    if (!calibrating) begin
                        cnt = (samples > DEPTH) ? DEPTH : int'(samples);
                        if (cnt > 0) begin
                            sum = '0;
                            for (int i = 0; i < cnt; i++) begin
                                sum += 64'(gap_mem[i]);
                                sorted.push_back(gap_mem[i]);
                            end
                            sorted.sort();
                            r.rpt.mean_latency = 32'(sum / 64'(cnt));
                            r.rpt.median_latency = sorted[cnt >> 1];
                        end
                        r.rpt.wrap_count = wraps;
                        r.has_stats = 1'b1;
                    end
                    pending_reports.push_back(r);
                    clear_window();
                end else begin
                    cnt = int'(samples) + int'(samples) / 2;
                    if (samples > DEPTH) cnt = DEPTH;
                    if (cnt > DEPTH) cnt = DEPTH;
                    if (cnt == 0) cnt = 1;
                    store_size = cnt;
                    calibrating = 1'b0;
                    samples = '0;
                    wr_index = 0;
                end
                offset_secs += 32'(interval_secs);
                deadline = deadline_after(t);
            end
            last_time = t;
            if (gap > max_gap) max_gap = gap;
            if (gap < min_gap) min_gap = gap;
        endfunction

        function void compare(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(logic [223:0] data, logic user);
            window_report_t e;
            report_t a;
            if (pending_reports.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none actual %h", $time, data);
                return;
            end
            e = pending_reports.pop_front();
            a = data[$bits(report_t)-1:0];
            compare("window_secs", e.rpt.window_secs, a.window_secs);
            compare("max_latency", e.rpt.max_latency, a.max_latency);
            compare("min_latency", e.rpt.min_latency, a.min_latency);
            compare("mean_latency", e.rpt.mean_latency, a.mean_latency);
            compare("median_latency", e.rpt.median_latency, a.median_latency);
            compare("sample_count", e.rpt.sample_count, a.sample_count);
            compare("wrap_count", e.rpt.wrap_count, a.wrap_count);
            compare("has_stats", e.has_stats, user);
        endfunction
    endclass

    logic         aclk = 1'b0;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [55:0]  s_tdata;    // timestamp_us[51:0], zero pad
    logic         s_tuser;    // command
    logic         m_tvalid;
    logic         m_tready;
    logic [223:0] m_tdata;    // window_secs up to wrap_count, zero pad
    logic         m_tuser;    // has_stats
    logic         cfg_valid;
    logic         cfg_ready;
    logic         cfg_index;
    logic [IVL_W-1:0] cfg_data;

    window_scoreboard latency_sb = new();
    logic [TIME_W-1:0] now_us;
    int  burst_left;
    int  cycle_count;
    bit  hold_request;
    int  hold_left;
    int  rx_mode;

    latency_window_statistics u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) latency_sb.check_result(m_tdata, m_tuser);
    end

    // The receiver switches between always ready, random and mostly stalled.
    always @(posedge aclk) begin
        if (cycle_count % 64 == 0) rx_mode <= $urandom_range(2);
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else if (hold_request) begin
            hold_request <= 1'b0;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (rx_mode == 0) begin
            m_tready <= 1'b1;
        end else if (rx_mode == 1) begin
            m_tready <= $urandom_range(1);
        end else begin
            m_tready <= ($urandom_range(3) == 0);
        end
    end

    task automatic write_cfg(logic idx, logic [IVL_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        latency_sb.write_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_request(logic cmd, logic [TIME_W-1:0] t);
        int gap_cycles;
        if (burst_left == 0) begin
            gap_cycles = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap_cycles > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap_cycles) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 20);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {4'b0, t};
        do @(posedge aclk); while (!s_tready);
        latency_sb.note_request(cmd, t);
        burst_left--;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (latency_sb.pending_reports.size() > 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic random_phase(logic [IVL_W-1:0] ivl, bit avg, int count);
        logic [63:0] scale;
        logic [63:0] next_t;
        int pick;
        drain();
        write_cfg(CFG_INTERVAL, ivl);
        write_cfg(CFG_AVERAGE, avg);
        scale = (ivl == 0) ? 64'd1000 : 64'(ivl) * 64'd125000;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 3) begin
                now_us = {$urandom, $urandom} & TIME_MAX;
                send_request(CMD_START, now_us);
            end else if (pick < 4) begin
                now_us = TIME_MAX - $urandom_range(3000000);
                send_request(CMD_START, now_us);
            end else if (pick < 6) begin
                send_request(1'b1, now_us - $urandom_range(2000));
            end else begin
                if (pick < 8) next_t = 64'(now_us) + {$urandom, $urandom};
                else next_t = 64'(now_us) + ({$urandom, $urandom} % (2 * scale + 1));
                now_us = (next_t > 64'(TIME_MAX)) ? TIME_MAX : next_t[TIME_W-1:0];
                send_request(1'b1, now_us);
            end
        end
    endtask

    initial begin
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= 1'b0;
        m_tready <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_INTERVAL;
        cfg_data <= '0;
        cycle_count = 0;
        hold_request = 1'b0;
        hold_left = 0;
        rx_mode = 0;
        burst_left = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // A sample before any start reports at once; then gap edge cases.
        send_request(1'b1, 52'd5);
        send_request(CMD_START, 52'd1000);
        send_request(1'b1, 52'd1000);
        send_request(1'b1, 52'd500);
        send_request(1'b1, 52'd500 + 52'h80000007);
        send_request(1'b1, 52'd500 + 52'h80000007);
        send_request(CMD_START, TIME_MAX - 52'd10);
        send_request(1'b1, TIME_MAX);
        send_request(CMD_START, 52'hA_5A5A_5A5A_5A5A);
        send_request(1'b1, 52'hA_5A5A_5A5A_5A5A + 52'd3000000);

        // Calibration window in average mode, followed by the first samples of a measured window.
        drain();
        write_cfg(CFG_INTERVAL, 12'd1);
        write_cfg(CFG_AVERAGE, 1'b1);
        send_request(CMD_START, 52'd0);
        for (int i = 1; i <= 12; i++) send_request(1'b1, 52'(i * 100000));
        now_us = 52'd1200000;

        random_phase(12'd2, 1'b0, 160);
        random_phase(12'd1, 1'b1, 200);
        random_phase(12'd1, 1'b0, 160);
        drain();
        hold_request = 1'b1;
        random_phase(12'd0, 1'b0, 160);
        random_phase(12'd3600, 1'b1, 180);
        random_phase(12'd0, 1'b1, 160);
        random_phase(12'd4095, 1'b0, 120);
        random_phase(12'd5, 1'b1, 200);
        random_phase(12'd2, 1'b1, 100);

        drain();
        if (latency_sb.pending_reports.size() > 0) begin
            latency_sb.errors++;
            $display("%0t: %0d results never arrived", $time,
                     latency_sb.pending_reports.size());
        end
        if (latency_sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
